// ===== hdl/pgrd_pkg.sv =====
// Shared types and constants for the PK glyph raster decoder.
// No dependencies; every other file in hdl/ uses this package.
package pgrd_pkg;

    // Fixed field widths
    localparam int NYB_W       = 4;
    localparam int DYN_F_W     = 4;
    localparam int DIM_W       = 7;
    localparam int ROW_INDEX_W = 6;
    localparam int ROW_BITS_W  = 64;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_DYN_F        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_FLAG   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd3;

    // Packed-number decode phases
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_ZEROS  = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    // Special nybble codes and decode constants
    localparam logic [NYB_W-1:0]   NYB_REPEAT     = 4'd14;
    localparam logic [NYB_W-1:0]   NYB_REPEAT_ONE = 4'd15;
    localparam logic [DYN_F_W-1:0] DYN_F_RAW      = 4'd14;
    localparam logic [3:0]         ZERO_CNT_MAX   = 4'hF;
    localparam int                 LONG_BIAS      = 193;
    localparam logic [7:0]         LONG_SCALE     = 8'd15;

    // Configuration register contents
    typedef struct packed {
        logic [DYN_F_W-1:0] dyn_f;
        logic               color_flag;
        logic [DIM_W-1:0]   glyph_width;
        logic [DIM_W-1:0]   glyph_height;
    } pgrd_cfg_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;
        logic raw_start;
        logic decode;
        logic seg;
        logic emit;
        logic flush;
    } pgrd_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic finished;
        logic raw_mode;
        logic dec_run;
        logic seg_idle;
        logic seg_row;
        logic row_more;
        logic pend_valid;
        logic out_free;
    } pgrd_stat_t;

endpackage

// ===== hdl/pgrd_if.sv =====
// Valid/ready channel interfaces for nybble input and row output.
// Depends on pgrd_pkg for field widths.
interface pgrd_in_if;
    logic                       valid;
    logic                       ready;
    logic [pgrd_pkg::NYB_W-1:0] nybble;
    logic                       new_glyph;

    modport source (output valid, output nybble, output new_glyph, input ready);
    modport sink   (input valid, input nybble, input new_glyph, output ready);
endinterface

interface pgrd_out_if;
    logic                             valid;
    logic                             ready;
    logic [pgrd_pkg::ROW_INDEX_W-1:0] row_index;
    logic [pgrd_pkg::ROW_BITS_W-1:0]  row_bits;
    logic                             last_of_run;
    logic                             glyph_done;

    modport source (output valid, output row_index, output row_bits, output last_of_run,
                    output glyph_done, input ready);
    modport sink   (input valid, input row_index, input row_bits, input last_of_run,
                    input glyph_done, output ready);
endinterface

// ===== hdl/pgrd_regs.sv =====
// APB-style configuration registers of the glyph raster decoder.
// Depends on pgrd_pkg; issues a registered restart pulse in the cycle after any write.
module pgrd_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pgrd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pgrd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pgrd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output pgrd_pkg::pgrd_cfg_t                 cfg,
    output logic                                cfg_restart
);
    import pgrd_pkg::*;

    logic [DYN_F_W-1:0]   dyn_f_reg;
    logic                 color_flag_reg;
    logic [DIM_W-1:0]     glyph_width_reg;
    logic [DIM_W-1:0]     glyph_height_reg;
    logic                 restart_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // Register writes; every write restarts the glyph on the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dyn_f_reg        <= '0;
            color_flag_reg   <= 1'b0;
            glyph_width_reg  <= DIM_W'(1);
            glyph_height_reg <= DIM_W'(1);
            restart_reg      <= 1'b0;
        end
        else
        begin
            restart_reg <= wr_en;
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_DYN_F:        dyn_f_reg        <= pwdata[DYN_F_W-1:0];
                    REG_COLOR_FLAG:   color_flag_reg   <= pwdata[0];
                    REG_GLYPH_WIDTH:  glyph_width_reg  <= pwdata[DIM_W-1:0];
                    REG_GLYPH_HEIGHT: glyph_height_reg <= pwdata[DIM_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_DYN_F:        prdata = APB_DATA_W'(dyn_f_reg);
            REG_COLOR_FLAG:   prdata = APB_DATA_W'(color_flag_reg);
            REG_GLYPH_WIDTH:  prdata = APB_DATA_W'(glyph_width_reg);
            REG_GLYPH_HEIGHT: prdata = APB_DATA_W'(glyph_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.dyn_f        = dyn_f_reg;
    assign cfg.color_flag   = color_flag_reg;
    assign cfg.glyph_width  = glyph_width_reg;
    assign cfg.glyph_height = glyph_height_reg;
    assign cfg_restart      = restart_reg;

endmodule

// ===== hdl/pgrd_ctrl.sv =====
// Sequencing state machine of the glyph raster decoder.
// Depends on pgrd_pkg; drives pgrd_dp through command and status structs.
module pgrd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pgrd_pkg::pgrd_stat_t  stat,
    output pgrd_pkg::pgrd_cmd_t   cmd
);
    import pgrd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_SEG   = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] done_state;

    // Where to go once the current nybble has no more work
    assign done_state = stat.pend_valid ? S_FLUSH : S_IDLE;
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.finished)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.raw_mode)
                begin
                    cmd.raw_start = 1'b1;
                    state_next    = S_SEG;
                end
                else
                begin
                    cmd.decode = 1'b1;
                    state_next = stat.dec_run ? S_SEG : S_IDLE;
                end
            end
            S_SEG:
            begin
                if (stat.seg_idle)
                begin
                    state_next = done_state;
                end
                else
                begin
                    cmd.seg    = 1'b1;
                    state_next = stat.seg_row ? S_ROW : done_state;
                end
            end
            S_ROW:
            begin
                // a held row moves on only when the output register frees up
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!stat.row_more)
                    begin
                        state_next = S_SEG;
                    end
                end
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/pgrd_dp.sv =====
// Datapath of the glyph raster decoder: packed-number decoder, run painter,
// row counters and the two-deep output holding stage. Depends on pgrd_pkg.
module pgrd_dp
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int RUN_BITS   = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  pgrd_pkg::pgrd_cfg_t                cfg,
    input  logic                               cfg_restart,
    input  pgrd_pkg::pgrd_cmd_t                cmd,
    output pgrd_pkg::pgrd_stat_t               stat,
    input  logic [pgrd_pkg::NYB_W-1:0]         in_nybble,
    input  logic                               in_new_glyph,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pgrd_pkg::ROW_INDEX_W-1:0]   out_row_index,
    output logic [pgrd_pkg::ROW_BITS_W-1:0]    out_row_bits,
    output logic                               out_last_of_run,
    output logic                               out_glyph_done
);
    import pgrd_pkg::*;

    localparam int                    COL_W   = $clog2(MAX_WIDTH + 1);
    localparam int                    ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam logic [RUN_BITS-1:0]   RUN_MAX = '1;
    localparam logic [DIM_W-1:0]      MAX_W_D = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]      MAX_H_D = DIM_W'(MAX_HEIGHT);

    // Decoder and raster state
    logic [MAX_WIDTH-1:0] store_reg,    store_next;
    logic [COL_W-1:0]     col_reg,      col_next;
    logic [ROW_W-1:0]     row_reg,      row_next;
    logic [RUN_BITS-1:0]  run_left_reg, run_left_next;
    logic                 color_reg,    color_next;
    logic [RUN_BITS-1:0]  repeat_reg,   repeat_next;
    logic [1:0]           ph_reg,       ph_next;
    logic                 rep_reg,      rep_next;
    logic [3:0]           zc_reg,       zc_next;
    logic [RUN_BITS-1:0]  accum_reg,    accum_next;
    logic                 fin_reg,      fin_next;
    logic [NYB_W-1:0]     nyb_reg,      nyb_next;
    logic [2:0]           raw_left_reg, raw_left_next;

    // Output holding stage and output register
    logic                   pend_valid_reg;
    logic [ROW_W-1:0]       pend_index_reg;
    logic [MAX_WIDTH-1:0]   pend_bits_reg;
    logic                   pend_done_reg;
    logic                   out_valid_reg;
    logic [ROW_W-1:0]       out_index_reg;
    logic [MAX_WIDTH-1:0]   out_bits_reg;
    logic                   out_last_reg;
    logic                   out_done_reg;

    // Effective geometry
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             raw_mode;
    logic             restart;

    // Packed-number decode
    logic                  dec_deliver;
    logic                  dec_rep_one;
    logic [RUN_BITS-1:0]   dec_val;
    logic [1:0]            dec_ph;
    logic                  dec_rep;
    logic [3:0]            dec_zc;
    logic [RUN_BITS-1:0]   dec_acc;
    logic [RUN_BITS+3:0]   acc_shift;
    logic [RUN_BITS-1:0]   acc_sat;
    logic [3:0]            zc_dec;
    logic [7:0]            f_scaled;
    logic signed [RUN_BITS+1:0] long_sum;
    logic [RUN_BITS-1:0]   long_val;
    logic [3:0]            two_hi;
    logic [8:0]            two_val;

    // Segment painter
    logic [RUN_BITS-1:0]  seg_len;
    logic [COL_W-1:0]     room;
    logic [COL_W-1:0]     seg_d;
    logic [COL_W:0]       col_end;
    logic [MAX_WIDTH-1:0] seg_mask;
    logic [MAX_WIDTH-1:0] seg_data;
    logic [NYB_W-1:0]     nyb_rev;
    logic [NYB_W-1:0]     raw_src;
    logic [2:0]           raw_used;
    logic                 seg_row;

    // Row emission
    logic [ROW_W-1:0] row_inc;
    logic             row_more;
    logic             out_free;

    // Clamp width and height into 1..max
    always_comb
    begin
        if (cfg.glyph_width == '0)
        begin
            w_eff = COL_W'(1);
        end
        else if (cfg.glyph_width > MAX_W_D)
        begin
            w_eff = COL_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = COL_W'(cfg.glyph_width);
        end

        if (cfg.glyph_height == '0)
        begin
            h_eff = ROW_W'(1);
        end
        else if (cfg.glyph_height > MAX_H_D)
        begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = ROW_W'(cfg.glyph_height);
        end
    end

    assign raw_mode = (cfg.dyn_f >= DYN_F_RAW);
    assign restart  = cfg_restart || (cmd.load && in_new_glyph);

    // Long-form arithmetic: accumulate one digit, then bias by 193 - 15*dyn_f
    assign acc_shift = {accum_reg, nyb_reg};
    assign acc_sat   = (acc_shift[RUN_BITS+3:RUN_BITS] != 4'd0) ? RUN_MAX
                                                                 : acc_shift[RUN_BITS-1:0];
    assign zc_dec    = (zc_reg != 4'd0) ? zc_reg - 4'd1 : 4'd0;
    assign f_scaled  = 8'(cfg.dyn_f) * LONG_SCALE;
    assign long_sum  = $signed({2'b00, acc_sat}) + $signed((RUN_BITS+2)'(LONG_BIAS))
                       - $signed((RUN_BITS+2)'(f_scaled));

    always_comb
    begin
        if (acc_sat == RUN_MAX)
        begin
            long_val = RUN_MAX;
        end
        else if (long_sum < 0)
        begin
            long_val = '0;
        end
        else if (long_sum[RUN_BITS] != 1'b0)
        begin
            long_val = RUN_MAX;
        end
        else
        begin
            long_val = long_sum[RUN_BITS-1:0];
        end
    end

    // Two-nybble form: (first - dyn_f - 1) * 16 + second + dyn_f + 1
    assign two_hi  = accum_reg[3:0] - cfg.dyn_f - 4'd1;
    assign two_val = {1'b0, two_hi, nyb_reg} + 9'(cfg.dyn_f) + 9'd1;

    // Packed-number phase step
    always_comb
    begin
        dec_deliver = 1'b0;
        dec_rep_one = 1'b0;
        dec_val     = '0;
        dec_ph      = ph_reg;
        dec_rep     = rep_reg;
        dec_zc      = zc_reg;
        dec_acc     = accum_reg;
        unique case (ph_reg)
            PH_FIRST:
            begin
                if (nyb_reg == 4'd0)
                begin
                    dec_zc = 4'd1;
                    dec_ph = PH_ZEROS;
                end
                else if (nyb_reg <= cfg.dyn_f)
                begin
                    dec_deliver = 1'b1;
                    dec_val     = RUN_BITS'(nyb_reg);
                end
                else if (nyb_reg < NYB_REPEAT)
                begin
                    dec_acc = RUN_BITS'(nyb_reg);
                    dec_ph  = PH_SECOND;
                end
                else if (!rep_reg)
                begin
                    if (nyb_reg == NYB_REPEAT)
                    begin
                        dec_rep = 1'b1;
                    end
                    else if (nyb_reg == NYB_REPEAT_ONE)
                    begin
                        dec_rep_one = 1'b1;
                    end
                end
            end
            PH_ZEROS:
            begin
                if (nyb_reg == 4'd0)
                begin
                    if (zc_reg != ZERO_CNT_MAX)
                    begin
                        dec_zc = zc_reg + 4'd1;
                    end
                end
                else
                begin
                    dec_acc = RUN_BITS'(nyb_reg);
                    dec_ph  = PH_DIGITS;
                end
            end
            PH_DIGITS:
            begin
                dec_acc = acc_sat;
                dec_zc  = zc_dec;
                if (zc_dec == 4'd0)
                begin
                    dec_deliver = 1'b1;
                    dec_val     = long_val;
                end
            end
            PH_SECOND:
            begin
                dec_deliver = 1'b1;
                dec_val     = RUN_BITS'(two_val);
            end
            default:
            begin
                dec_ph = PH_FIRST;
            end
        endcase
        if (dec_deliver)
        begin
            dec_ph  = PH_FIRST;
            dec_rep = 1'b0;
        end
    end

    // Segment: paint min(remaining, room) pixels starting at the column
    assign seg_len  = raw_mode ? RUN_BITS'(raw_left_reg) : run_left_reg;
    assign room     = w_eff - col_reg;
    assign seg_d    = (seg_len < RUN_BITS'(room)) ? COL_W'(seg_len) : room;
    assign col_end  = {1'b0, col_reg} + {1'b0, seg_d};
    assign seg_row  = (col_end >= {1'b0, w_eff});
    assign nyb_rev  = {nyb_reg[0], nyb_reg[1], nyb_reg[2], nyb_reg[3]};
    assign raw_used = 3'(NYB_W) - raw_left_reg;
    assign raw_src  = nyb_rev >> raw_used;

    always_comb
    begin
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            seg_mask[x] = ((COL_W+1)'(x) >= {1'b0, col_reg}) && ((COL_W+1)'(x) < col_end);
        end
        if (raw_mode)
        begin
            seg_data = MAX_WIDTH'(raw_src) << col_reg;
        end
        else
        begin
            seg_data = {MAX_WIDTH{color_reg}};
        end
    end

    // Row emission bookkeeping
    assign row_inc  = row_reg + ROW_W'(1);
    assign row_more = (repeat_reg != '0) && (row_inc < h_eff);
    assign out_free = !out_valid_reg || out_ready;

    // Next-state logic of the decoder and raster state
    always_comb
    begin
        store_next    = store_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        run_left_next = run_left_reg;
        color_next    = color_reg;
        repeat_next   = repeat_reg;
        ph_next       = ph_reg;
        rep_next      = rep_reg;
        zc_next       = zc_reg;
        accum_next    = accum_reg;
        fin_next      = fin_reg;
        nyb_next      = nyb_reg;
        raw_left_next = raw_left_reg;

        if (cmd.load)
        begin
            nyb_next = in_nybble;
        end

        if (restart)
        begin
            store_next    = '0;
            col_next      = '0;
            row_next      = '0;
            run_left_next = '0;
            color_next    = cfg.color_flag;
            repeat_next   = '0;
            ph_next       = PH_FIRST;
            rep_next      = 1'b0;
            zc_next       = '0;
            accum_next    = '0;
            fin_next      = 1'b0;
            raw_left_next = '0;
        end
        else if (cmd.raw_start)
        begin
            raw_left_next = 3'(NYB_W);
        end
        else if (cmd.decode)
        begin
            ph_next    = dec_ph;
            rep_next   = dec_rep;
            zc_next    = dec_zc;
            accum_next = dec_acc;
            if (dec_rep_one)
            begin
                repeat_next = RUN_BITS'(1);
            end
            if (dec_deliver)
            begin
                if (rep_reg)
                begin
                    repeat_next = dec_val;
                end
                else
                begin
                    run_left_next = dec_val;
                    color_next    = !color_reg;
                end
            end
        end
        else if (cmd.seg)
        begin
            store_next = store_reg | (seg_data & seg_mask);
            col_next   = col_end[COL_W-1:0];
            if (raw_mode)
            begin
                raw_left_next = raw_left_reg - 3'(seg_d);
            end
            else
            begin
                run_left_next = run_left_reg - RUN_BITS'(seg_d);
            end
        end
        else if (cmd.emit)
        begin
            row_next = row_inc;
            if (row_more)
            begin
                repeat_next = repeat_reg - RUN_BITS'(1);
            end
            else
            begin
                store_next = '0;
                col_next   = '0;
                fin_next   = (row_inc >= h_eff);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg    <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            run_left_reg <= '0;
            color_reg    <= 1'b0;
            repeat_reg   <= '0;
            ph_reg       <= PH_FIRST;
            rep_reg      <= 1'b0;
            zc_reg       <= '0;
            accum_reg    <= '0;
            fin_reg      <= 1'b0;
            nyb_reg      <= '0;
            raw_left_reg <= '0;
        end
        else
        begin
            store_reg    <= store_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            run_left_reg <= run_left_next;
            color_reg    <= color_next;
            repeat_reg   <= repeat_next;
            ph_reg       <= ph_next;
            rep_reg      <= rep_next;
            zc_reg       <= zc_next;
            accum_reg    <= accum_next;
            fin_reg      <= fin_next;
            nyb_reg      <= nyb_next;
            raw_left_reg <= raw_left_next;
        end
    end

    // Output stage control: a row waits in the holding stage until the next
    // row arrives (not last) or the nybble is done (last)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((cmd.emit && pend_valid_reg) || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_index_reg <= row_reg;
            pend_bits_reg  <= store_reg;
            pend_done_reg  <= (row_inc == h_eff);
        end
        if ((cmd.emit && pend_valid_reg) || cmd.flush)
        begin
            out_index_reg <= pend_index_reg;
            out_bits_reg  <= pend_bits_reg;
            out_done_reg  <= pend_done_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_row_index   = ROW_INDEX_W'(out_index_reg);
    assign out_row_bits    = ROW_BITS_W'(out_bits_reg);
    assign out_last_of_run = out_last_reg;
    assign out_glyph_done  = out_done_reg;

    // Status back to the controller
    assign stat.finished   = fin_reg;
    assign stat.raw_mode   = raw_mode;
    assign stat.dec_run    = dec_deliver && !rep_reg;
    assign stat.seg_idle   = fin_reg || (seg_len == '0);
    assign stat.seg_row    = seg_row;
    assign stat.row_more   = row_more;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

endmodule

// ===== hdl/pk_glyph_raster_decoder_unit.sv =====
// PK glyph raster decoder, top level. Takes one nybble of a glyph's packed
// raster per transaction and returns finished rows. Each nybble is loaded,
// then decoded; one that produces no pixels ends there, and one that delivers
// a run or four raw bits is placed by the painter. Every emitted row, repeats
// included, is a step of its own, the painter resumes after every row that it
// completes, and the last row caused by a nybble is then handed to the output
// register. All of this is done by the single run painter, which places one
// run piece or emits one row per cycle, except that a held row waits for a
// free output register. A nybble is taken only after the previous one is
// fully worked off; rows wait in a two-deep output stage while the sink
// stalls. Configuration writes restart the glyph.
// Depends on pgrd_pkg, pgrd_if, pgrd_regs, pgrd_ctrl and pgrd_dp.
module pk_glyph_raster_decoder_unit
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int RUN_BITS   = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pgrd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pgrd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pgrd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    pgrd_in_if.sink                          nybbles,
    pgrd_out_if.source                       rows
);
    import pgrd_pkg::*;

    pgrd_cfg_t  cfg;
    pgrd_cmd_t  cmd;
    pgrd_stat_t stat;
    logic       cfg_restart;
    logic       in_ready;

    // Configuration registers
    pgrd_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .cfg_restart (cfg_restart)
    );

    // Sequencer
    pgrd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (nybbles.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign nybbles.ready = in_ready;

    // Decoder, painter and output stage
    pgrd_dp
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RUN_BITS   (RUN_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cfg_restart     (cfg_restart),
        .cmd             (cmd),
        .stat            (stat),
        .in_nybble       (nybbles.nybble),
        .in_new_glyph    (nybbles.new_glyph),
        .out_valid       (rows.valid),
        .out_ready       (rows.ready),
        .out_row_index   (rows.row_index),
        .out_row_bits    (rows.row_bits),
        .out_last_of_run (rows.last_of_run),
        .out_glyph_done  (rows.glyph_done)
    );

endmodule

// ===== hdl/pgrd_checker.sv =====
// Port-level assertions for pk_glyph_raster_decoder_unit, bound to the top.
// Depends on pgrd_pkg for field widths.
module pgrd_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [pgrd_pkg::ROW_INDEX_W-1:0]    out_row_index,
    input logic [pgrd_pkg::ROW_BITS_W-1:0]     out_row_bits,
    input logic                                out_last_of_run,
    input logic                                out_glyph_done
);
    // A stalled row holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row_bits)
                                    && $stable(out_row_index))
        else $error("row changed while stalled");

    // One nybble at a time: ready drops right after a transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("nybble taken while previous one in progress");

    // The glyph's final row is always the last row of its nybble
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_glyph_done |-> out_last_of_run)
        else $error("final row not marked last");

    // A new nybble is taken only once every row of the previous one has reached the output register
    a_in_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> out_last_of_run)
        else $error("nybble taken with rows of previous one pending");

endmodule

bind pk_glyph_raster_decoder_unit pgrd_checker u_pgrd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (nybbles.valid),
    .in_ready        (nybbles.ready),
    .out_valid       (rows.valid),
    .out_ready       (rows.ready),
    .out_row_index   (rows.row_index),
    .out_row_bits    (rows.row_bits),
    .out_last_of_run (rows.last_of_run),
    .out_glyph_done  (rows.glyph_done)
);
